FILE: rtl/sfm_pkg.sv
// ----------------------------------------------------------------------------
// sfm_pkg
// shared types and constants of the single-precision multiplier
// ----------------------------------------------------------------------------
package sfm_pkg;

    localparam int unsigned WORD_W = 32;
    localparam int unsigned EXP_W  = 8;
    localparam int unsigned FRAC_W = 23;
    localparam int unsigned HI_W   = 13;
    localparam int unsigned LO_W   = 11;
    localparam int unsigned SUM_W  = 26;
    localparam int unsigned EXP_SUM_W = 10;

    localparam logic [EXP_W-1:0] EXP_INF = 8'd255;
    localparam logic [EXP_SUM_W-1:0] BIAS_HI = 10'd126;
    localparam logic [EXP_SUM_W-1:0] BIAS_LO = 10'd127;
    localparam logic [EXP_SUM_W:0] EXP_MAX_FIN = 11'd254;

    typedef struct packed {
        logic              sign;
        logic              zero;
        logic [EXP_SUM_W-1:0] exp_sum;
    } t_side;

endpackage

FILE: rtl/sfm_mul_stage.sv
// ----------------------------------------------------------------------------
// sfm_mul_stage
// stages one and two: operand split, partial products, mantissa sum
// ----------------------------------------------------------------------------
module sfm_mul_stage (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_en,
    input  logic                         i_valid,
    input  logic [sfm_pkg::WORD_W-1:0]   i_operand_a,
    input  logic [sfm_pkg::WORD_W-1:0]   i_operand_b,
    output logic                         o_valid,
    output sfm_pkg::t_side               o_side,
    output logic [sfm_pkg::SUM_W-1:0]    o_sum
);

    logic [23:0] w_ma, w_mb;
    logic                      r_v1, r_v2;
    sfm_pkg::t_side            r_side1, r_side2;
    logic [25:0]               r_hh;
    logic [23:0]               r_hl, r_lh;
    logic [sfm_pkg::SUM_W-1:0] r_sum;

    assign w_ma = {1'b1, i_operand_a[22:0]};
    assign w_mb = {1'b1, i_operand_b[22:0]};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        if (i_en) begin
            r_side1.sign    <= i_operand_a[31] ^ i_operand_b[31];
            r_side1.zero    <= (i_operand_a[30:23] == '0) || (i_operand_b[30:23] == '0);
            r_side1.exp_sum <= {2'b00, i_operand_a[30:23]} + {2'b00, i_operand_b[30:23]};
            r_hh <= w_ma[23:11] * w_mb[23:11];
            r_hl <= w_ma[23:11] * w_mb[10:0];
            r_lh <= w_ma[10:0] * w_mb[23:11];
            r_side2 <= r_side1;
            r_sum   <= r_hh + {13'd0, r_hl[23:11]} + {13'd0, r_lh[23:11]} + 26'd2;
        end
    end

    assign o_valid = r_v2;
    assign o_side  = r_side2;
    assign o_sum   = r_sum;

endmodule

FILE: rtl/sfm_pack_stage.sv
// ----------------------------------------------------------------------------
// sfm_pack_stage
// stage three: normalize, exponent range check, result packing
// ----------------------------------------------------------------------------
module sfm_pack_stage (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  sfm_pkg::t_side              i_side,
    input  logic [sfm_pkg::SUM_W-1:0]   i_sum,
    output logic                        o_valid,
    output logic [sfm_pkg::WORD_W-1:0]  o_product
);

    logic                        r_valid;
    logic [sfm_pkg::WORD_W-1:0]  r_product;
    logic [sfm_pkg::FRAC_W-1:0]  w_frac;
    logic [sfm_pkg::EXP_SUM_W:0] w_e;
    logic                        w_under, w_over;
    logic [sfm_pkg::WORD_W-1:0]  n_product;

    always_comb begin
        if (i_sum[25]) begin
            w_frac = i_sum[24:2];
            w_e = {1'b0, i_side.exp_sum} - {1'b0, sfm_pkg::BIAS_HI};
        end else begin
            w_frac = i_sum[23:1];
            w_e = {1'b0, i_side.exp_sum} - {1'b0, sfm_pkg::BIAS_LO};
        end
        w_under = w_e[sfm_pkg::EXP_SUM_W] || (w_e == '0) || i_side.zero;
        w_over  = w_e > sfm_pkg::EXP_MAX_FIN;
        if (w_under) begin
            n_product = {i_side.sign, 31'd0};
        end else if (w_over) begin
            n_product = {i_side.sign, sfm_pkg::EXP_INF, 23'd0};
        end else begin
            n_product = {i_side.sign, w_e[7:0], w_frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_product <= n_product;
        end
    end

    assign o_valid   = r_valid;
    assign o_product = r_product;

endmodule

FILE: rtl/single_float_multiplier_core.sv
// ----------------------------------------------------------------------------
// single_float_multiplier_core
// simplified single-precision multiply, truncating, flush to zero
// ----------------------------------------------------------------------------
// channel | ports                                  | direction
// in      | i_valid, o_stall, i_operand_a/b        | transaction in
// out     | o_valid, i_stall, o_product            | transaction out
//
// three register stages, one transaction per cycle while the output is not stalled
// every stage is fully pipelined, so a new transaction can enter each cycle without a stall
// synchronous active-low reset clears the valid bits only
// a stall at the output while o_valid is high freezes every stage, including each one that holds a transaction
// ----------------------------------------------------------------------------
module single_float_multiplier_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_operand_a,
    input  logic [31:0] i_operand_b,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_product
);

    logic                      w_en;
    logic                      w_v2;
    sfm_pkg::t_side            w_side;
    logic [sfm_pkg::SUM_W-1:0] w_sum;

    assign w_en    = !(o_valid && i_stall);
    assign o_stall = !w_en;

    sfm_mul_stage u_mul (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid,
        .i_operand_a, .i_operand_b,
        .o_valid(w_v2), .o_side(w_side), .o_sum(w_sum)
    );

    sfm_pack_stage u_pack (
        .i_clk, .i_rst_n, .i_en(w_en), .i_valid(w_v2),
        .i_side(w_side), .i_sum(w_sum),
        .o_valid, .o_product
    );

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_product)))
        else $error("held result changed");
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("stall without blocked output");
    a_flow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_stall && i_valid) |-> ##3 (o_valid || $past(o_stall) || $past(o_stall,2)))
        else $error("transaction lost");

endmodule
